// File: rtl/rvrb_pkg.sv
// Shared types, sizes and field layout for the range variable registry binder.
package rvrb_pkg;

   // Storage sizes
   localparam int REGISTRY_DEPTH = 64;
   localparam int BIND_DEPTH     = 8;

   // Derived widths
   localparam int ADDR_W  = $clog2(REGISTRY_DEPTH);
   localparam int NEXT_W  = $clog2(REGISTRY_DEPTH + 1);
   localparam int COUNT_W = $clog2(BIND_DEPTH + 1);
   localparam int SLOT_W  = (BIND_DEPTH > 1) ? $clog2(BIND_DEPTH) : 1;

   // Fixed field widths
   localparam int KIND_W  = 3;
   localparam int DATA_W  = 32;
   localparam int IDENT_W = 31;
   localparam int NID_W   = 6;

   // Request tdata layout, lowest bit first
   localparam int IN_LOWER_LSB = 0;
   localparam int IN_UPPER_LSB = IN_LOWER_LSB + DATA_W;
   localparam int IN_IDENT_LSB = IN_UPPER_LSB + DATA_W;
   localparam int IN_VALUE_LSB = IN_IDENT_LSB + IDENT_W;
   localparam int IN_PEXT_LSB  = IN_VALUE_LSB + DATA_W;
   localparam int IN_USED_W    = IN_PEXT_LSB + DATA_W;
   localparam int IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;

   // Response tdata layout, lowest bit first
   localparam int OUT_OK_LSB    = 0;
   localparam int OUT_NID_LSB   = OUT_OK_LSB + 1;
   localparam int OUT_LOWER_LSB = OUT_NID_LSB + NID_W;
   localparam int OUT_UPPER_LSB = OUT_LOWER_LSB + DATA_W;
   localparam int OUT_VALUE_LSB = OUT_UPPER_LSB + DATA_W;
   localparam int OUT_COUNT_LSB = OUT_VALUE_LSB + DATA_W;
   localparam int OUT_USED_W    = OUT_COUNT_LSB + NID_W;
   localparam int OUT_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;
   localparam int OUT_PAD_W     = OUT_DATA_W - OUT_USED_W;

   // Request kinds; codes six and seven are unused
   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC     = 3'd0,
      KIND_BIND      = 3'd1,
      KIND_QUERY     = 3'd2,
      KIND_RESOLVE   = 3'd3,
      KIND_CLR_REG   = 3'd4,
      KIND_CLR_BIND  = 3'd5
   } kind_type;

   // Control sequence
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   // Registry memory access
   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_lower;
      logic [DATA_W-1:0] wr_upper;
   } mem_req_type;

   // Binding table command and status
   typedef struct packed {
      logic               bind_en;
      logic               clear_en;
      logic [IDENT_W-1:0] ident;
      logic [DATA_W-1:0]  value;
   } bind_cmd_type;

   typedef struct packed {
      logic              hit;
      logic              full;
      logic [DATA_W-1:0] value;
   } bind_stat_type;

endpackage

// File: rtl/rvrb_reg_mem.sv
// Registry memory holding the lower and upper bound of each variable id.
module rvrb_reg_mem (
   input  logic                          clock,
   input  rvrb_pkg::mem_req_type         mem_req,
   output logic [rvrb_pkg::DATA_W-1:0]   rd_lower,
   output logic [rvrb_pkg::DATA_W-1:0]   rd_upper
);

   logic [2*rvrb_pkg::DATA_W-1:0] mem_ff [rvrb_pkg::REGISTRY_DEPTH];
   logic [2*rvrb_pkg::DATA_W-1:0] rd_data_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= {mem_req.wr_upper, mem_req.wr_lower};
      end
   end

   // Read one entry; hold the read data until the next read
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_lower = rd_data_ff[rvrb_pkg::DATA_W-1:0];
   assign rd_upper = rd_data_ff[2*rvrb_pkg::DATA_W-1:rvrb_pkg::DATA_W];

endmodule

// File: rtl/rvrb_bind_table.sv
// Binding table: id/value pairs with a parallel lookup and append or overwrite.
module rvrb_bind_table (
   input  logic                     clock,
   input  logic                     reset,
   input  rvrb_pkg::bind_cmd_type   bind_cmd,
   output rvrb_pkg::bind_stat_type  bind_stat
);

   logic [rvrb_pkg::IDENT_W-1:0] ident_ff [rvrb_pkg::BIND_DEPTH];
   logic [rvrb_pkg::DATA_W-1:0]  value_ff [rvrb_pkg::BIND_DEPTH];
   logic [rvrb_pkg::COUNT_W-1:0] count_ff;
   logic [rvrb_pkg::COUNT_W-1:0] count_in;
   logic                         hit;
   logic [rvrb_pkg::SLOT_W-1:0]  hit_slot;
   logic [rvrb_pkg::SLOT_W-1:0]  wr_slot;
   logic                         full;
   logic                         wr_en;

   // Compare every live entry against the lookup id, take the first match
   always_comb begin
      hit      = 1'b0;
      hit_slot = '0;
      for (int i = 0; i < rvrb_pkg::BIND_DEPTH; i++) begin
         if (!hit && (rvrb_pkg::COUNT_W'(i) < count_ff) &&
             (ident_ff[i] == bind_cmd.ident)) begin
            hit      = 1'b1;
            hit_slot = rvrb_pkg::SLOT_W'(i);
         end
      end
   end

   assign full = (count_ff == rvrb_pkg::COUNT_W'(rvrb_pkg::BIND_DEPTH));

   assign bind_stat.hit   = hit;
   assign bind_stat.full  = full;
   assign bind_stat.value = value_ff[hit_slot];

   // Overwrite on a match, otherwise append while there is room
   assign wr_en   = bind_cmd.bind_en && (bind_cmd.ident != '0) && (hit || !full);
   assign wr_slot = hit ? hit_slot : count_ff[rvrb_pkg::SLOT_W-1:0];

   always_comb begin
      count_in = count_ff;
      if (bind_cmd.clear_en) begin
         count_in = '0;
      end else if (wr_en && !hit) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Store the pair
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ident_ff[wr_slot] <= bind_cmd.ident;
         value_ff[wr_slot] <= bind_cmd.value;
      end
   end

endmodule

// File: rtl/range_variable_registry_binder_top.sv
// Top level of the range variable registry binder: request control and response register.
//
// One request gives one response. Taking a request starts the registered read
// of the registry memory; in the execute state the read bounds are combined with
// the parallel binding-table lookup and the response register is loaded. When the
// response register still holds an untaken response, the execute state waits
// until that transfer takes place. The registry and the binding table need no
// clearing pass after reset.
module range_variable_registry_binder_top (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // lower_bound, upper_bound, var_ident, bind_value, extent word, zero pad
   input  logic [rvrb_pkg::IN_DATA_W-1:0]     req_tdata,
   // kind
   input  logic [rvrb_pkg::KIND_W-1:0]        req_tuser,
   // Response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // ok, new_ident, lower_out, upper_out, value_out, registered_count, zero pad
   output logic [rvrb_pkg::OUT_DATA_W-1:0]    rsp_tdata,
   // from_binding
   output logic                               rsp_tuser
);

   rvrb_pkg::state_type      state_ff, state_in;
   logic [rvrb_pkg::NEXT_W-1:0] next_ident_ff, next_ident_in;
   logic [rvrb_pkg::IN_DATA_W-1:0] req_data_ff;
   logic [rvrb_pkg::KIND_W-1:0]    kind_ff;
   logic                            rsp_valid_ff;
   logic [rvrb_pkg::OUT_USED_W-1:0] rsp_data_ff, rsp_data_in;
   logic                            rsp_user_ff, rsp_user_in;

   logic                            accept;
   logic                            commit;
   logic [rvrb_pkg::KIND_W-1:0]     req_kind;
   logic [rvrb_pkg::DATA_W-1:0]     req_pext;

   logic [rvrb_pkg::DATA_W-1:0]     lower_q, upper_q, value_q, pext_q;
   logic [rvrb_pkg::IDENT_W-1:0]    ident_q, pext_ident;
   logic                            ident_known, pext_known, alloc_ok;

   logic                            ok;
   logic [rvrb_pkg::NID_W-1:0]      new_ident, reg_count;
   logic [rvrb_pkg::DATA_W-1:0]     lower_out, upper_out, value_out;
   logic                            from_binding;

   rvrb_pkg::mem_req_type           mem_req;
   logic [rvrb_pkg::DATA_W-1:0]     rd_lower, rd_upper;
   rvrb_pkg::bind_cmd_type          bind_cmd;
   rvrb_pkg::bind_stat_type         bind_stat;

   // Handshakes
   assign req_tready = (state_ff == rvrb_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign commit     = (state_ff == rvrb_pkg::ST_EXEC) && (!rsp_valid_ff || rsp_tready);

   // Incoming fields used for the memory read address
   assign req_kind = req_tuser;
   assign req_pext = req_tdata[rvrb_pkg::IN_PEXT_LSB +: rvrb_pkg::DATA_W];

   // Latched request fields
   assign lower_q    = req_data_ff[rvrb_pkg::IN_LOWER_LSB +: rvrb_pkg::DATA_W];
   assign upper_q    = req_data_ff[rvrb_pkg::IN_UPPER_LSB +: rvrb_pkg::DATA_W];
   assign ident_q    = req_data_ff[rvrb_pkg::IN_IDENT_LSB +: rvrb_pkg::IDENT_W];
   assign value_q    = req_data_ff[rvrb_pkg::IN_VALUE_LSB +: rvrb_pkg::DATA_W];
   assign pext_q     = req_data_ff[rvrb_pkg::IN_PEXT_LSB +: rvrb_pkg::DATA_W];
   assign pext_ident = pext_q[rvrb_pkg::IDENT_W-1:0];

   // Registry memory
   rvrb_reg_mem u_reg_mem (
      .clock    (clock),
      .mem_req  (mem_req),
      .rd_lower (rd_lower),
      .rd_upper (rd_upper)
   );

   // Binding table
   rvrb_bind_table u_bind_table (
      .clock     (clock),
      .reset     (reset),
      .bind_cmd  (bind_cmd),
      .bind_stat (bind_stat)
   );

   // Registry checks on the latched request
   assign ident_known = (ident_q != '0) &&
                        (ident_q < rvrb_pkg::IDENT_W'(next_ident_ff));
   assign pext_known  = (pext_ident != '0) &&
                        (pext_ident < rvrb_pkg::IDENT_W'(next_ident_ff));
   assign alloc_ok    = (next_ident_ff < rvrb_pkg::NEXT_W'(rvrb_pkg::REGISTRY_DEPTH)) &&
                        (upper_q != '0) && (upper_q >= lower_q);

   // Issue the memory read on a transfer, form the response and the updates
   always_comb begin
      mem_req.rd_en    = accept;
      mem_req.rd_addr  = (req_kind == rvrb_pkg::KIND_RESOLVE) ?
                         req_pext[rvrb_pkg::ADDR_W-1:0] :
                         req_tdata[rvrb_pkg::IN_IDENT_LSB +: rvrb_pkg::ADDR_W];
      mem_req.wr_en    = 1'b0;
      mem_req.wr_addr  = next_ident_ff[rvrb_pkg::ADDR_W-1:0];
      mem_req.wr_lower = lower_q;
      mem_req.wr_upper = upper_q;

      bind_cmd.bind_en  = 1'b0;
      bind_cmd.clear_en = 1'b0;
      bind_cmd.ident    = ident_q;
      bind_cmd.value    = value_q;

      next_ident_in = next_ident_ff;
      ok            = 1'b0;
      new_ident     = '0;
      lower_out     = '0;
      upper_out     = '0;
      value_out     = '0;
      from_binding  = 1'b0;

      unique case (kind_ff)
         rvrb_pkg::KIND_ALLOC: begin
            if (alloc_ok) begin
               ok            = 1'b1;
               new_ident     = rvrb_pkg::NID_W'(next_ident_ff);
               mem_req.wr_en = commit;
               next_ident_in = commit ? next_ident_ff + 1'b1 : next_ident_ff;
            end
         end
         rvrb_pkg::KIND_BIND: begin
            ok               = (ident_q != '0) && (bind_stat.hit || !bind_stat.full);
            bind_cmd.bind_en = commit;
         end
         rvrb_pkg::KIND_QUERY: begin
            ok           = ident_known;
            lower_out    = ident_known ? rd_lower : '0;
            upper_out    = ident_known ? rd_upper : '0;
            from_binding = bind_stat.hit;
            value_out    = bind_stat.hit ? bind_stat.value : upper_out;
         end
         rvrb_pkg::KIND_RESOLVE: begin
            if (!pext_q[rvrb_pkg::DATA_W-1]) begin
               value_out = pext_q;
            end else begin
               value_out = pext_known ? rd_upper : '0;
            end
         end
         rvrb_pkg::KIND_CLR_REG: begin
            next_ident_in = commit ? rvrb_pkg::NEXT_W'(1) : next_ident_ff;
         end
         rvrb_pkg::KIND_CLR_BIND: begin
            bind_cmd.clear_en = commit;
         end
         default: begin
            // Unused kinds leave the state alone
         end
      endcase

      reg_count   = rvrb_pkg::NID_W'(next_ident_in - 1'b1);
      rsp_data_in = {reg_count, value_out, upper_out, lower_out, new_ident, ok};
      rsp_user_in = from_binding;
   end

   // Advance the sequence
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rvrb_pkg::ST_IDLE: if (accept) state_in = rvrb_pkg::ST_EXEC;
         rvrb_pkg::ST_EXEC: if (commit) state_in = rvrb_pkg::ST_IDLE;
         default:           state_in = rvrb_pkg::ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rvrb_pkg::ST_IDLE;
         next_ident_ff <= rvrb_pkg::NEXT_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         next_ident_ff <= next_ident_in;
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the request and the response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         req_data_ff <= req_tdata;
         kind_ff     <= req_tuser;
      end
      if (commit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{rvrb_pkg::OUT_PAD_W{1'b0}}, rsp_data_ff};
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTH
   // Next id stays within one and the registry depth
   a_next_range: assert property (@(posedge clock) disable iff (reset)
      (next_ident_ff != '0) &&
      (next_ident_ff <= rvrb_pkg::NEXT_W'(rvrb_pkg::REGISTRY_DEPTH)))
      else $error("next id out of range");

   // A successful allocate advances the next id by one
   a_alloc_step: assert property (@(posedge clock) disable iff (reset)
      (commit && (kind_ff == rvrb_pkg::KIND_ALLOC) && alloc_ok) |=>
      (next_ident_ff == $past(next_ident_ff) + 1'b1))
      else $error("allocate did not advance the next id");

   // A new response appears only after the execute cycle
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == rvrb_pkg::ST_EXEC))
      else $error("response raised without an execute cycle");

   // A nonzero new id always comes with ok
   a_nid_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff[rvrb_pkg::OUT_NID_LSB +: rvrb_pkg::NID_W] != '0)) |->
      rsp_data_ff[rvrb_pkg::OUT_OK_LSB])
      else $error("new id without ok");
`endif

endmodule

// File: tb/range_variable_registry_binder_top_test.sv
// Self-checking stream testbench for the range variable registry binder top level.
`timescale 1ns / 100ps

module range_variable_registry_binder_top_test;

   // Codes six and seven carry no operation
   localparam logic [rvrb_pkg::KIND_W-1:0] KIND_SPARE_6 = 3'd6;
   localparam logic [rvrb_pkg::KIND_W-1:0] KIND_SPARE_7 = 3'd7;

   localparam int RANDOM_ITEMS   = 1250;
   localparam int MAX_FILLS      = 5;
   localparam int STALL_MAX      = 14;
   localparam int IDLE_LIMIT     = 4000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int PRINT_LIMIT    = 40;

   typedef logic [rvrb_pkg::DATA_W-1:0] word_type;

   typedef struct {
      logic [rvrb_pkg::KIND_W-1:0]  kind;
      logic [rvrb_pkg::DATA_W-1:0]  lower;
      logic [rvrb_pkg::DATA_W-1:0]  upper;
      logic [rvrb_pkg::IDENT_W-1:0] ident;
      logic [rvrb_pkg::DATA_W-1:0]  value;
      logic [rvrb_pkg::DATA_W-1:0]  pext;
      bit                           drain;   // hold off until every response is back
   } req_type;

   typedef struct {
      logic                        ok;
      logic [rvrb_pkg::NID_W-1:0]  nid;
      logic [rvrb_pkg::DATA_W-1:0] lower;
      logic [rvrb_pkg::DATA_W-1:0] upper;
      logic [rvrb_pkg::DATA_W-1:0] value;
      logic                        fb;
      logic [rvrb_pkg::NID_W-1:0]  count;
   } rsp_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [rvrb_pkg::IN_DATA_W-1:0]  req_tdata  = '0;
   logic [rvrb_pkg::KIND_W-1:0]     req_tuser  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [rvrb_pkg::OUT_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser;

   range_variable_registry_binder_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Clock: 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   req_type queued_requests[$];
   rsp_type expected_responses[$];
   int      mismatches = 0;
   int      responses_seen = 0;

   // Shadow of the registry and the binding table
   logic [rvrb_pkg::DATA_W-1:0]  shadow_lower[rvrb_pkg::REGISTRY_DEPTH];
   logic [rvrb_pkg::DATA_W-1:0]  shadow_upper[rvrb_pkg::REGISTRY_DEPTH];
   int                           shadow_next = 1;
   logic [rvrb_pkg::IDENT_W-1:0] shadow_bind_ident[rvrb_pkg::BIND_DEPTH];
   logic [rvrb_pkg::DATA_W-1:0]  shadow_bind_value[rvrb_pkg::BIND_DEPTH];
   int                           shadow_bind_count = 0;

   function automatic bit is_registered(logic [rvrb_pkg::IDENT_W-1:0] id);
      return id != 0 && id < shadow_next && id < rvrb_pkg::REGISTRY_DEPTH;
   endfunction

   // Slot holding id, or -1 when it is not bound
   function automatic int binding_slot(logic [rvrb_pkg::IDENT_W-1:0] id);
      for (int i = 0; i < shadow_bind_count && i < rvrb_pkg::BIND_DEPTH; i++)
         if (shadow_bind_ident[rvrb_pkg::SLOT_W'(i)] == id) return i;
      return -1;
   endfunction

   // Work out the response to one accepted request and advance the shadow state
   function automatic rsp_type predict_response(req_type r);
      rsp_type                      p;
      int                           slot;
      logic [rvrb_pkg::IDENT_W-1:0] vid;
      p = '{ok: 1'b0, nid: '0, lower: '0, upper: '0, value: '0, fb: 1'b0, count: '0};
      slot = binding_slot(r.ident);
      case (r.kind)
         rvrb_pkg::KIND_ALLOC: begin
            if (shadow_next < rvrb_pkg::REGISTRY_DEPTH && r.upper != 0 &&
                r.upper >= r.lower) begin
               p.ok  = 1'b1;
               p.nid = rvrb_pkg::NID_W'(shadow_next);
               shadow_lower[rvrb_pkg::ADDR_W'(shadow_next)] = r.lower;
               shadow_upper[rvrb_pkg::ADDR_W'(shadow_next)] = r.upper;
               shadow_next++;
            end
         end
         rvrb_pkg::KIND_BIND: begin
            if (r.ident != 0) begin
               if (slot >= 0) begin
                  shadow_bind_value[rvrb_pkg::SLOT_W'(slot)] = r.value;
                  p.ok = 1'b1;
               end else if (shadow_bind_count < rvrb_pkg::BIND_DEPTH) begin
                  shadow_bind_ident[rvrb_pkg::SLOT_W'(shadow_bind_count)] = r.ident;
                  shadow_bind_value[rvrb_pkg::SLOT_W'(shadow_bind_count)] = r.value;
                  shadow_bind_count++;
                  p.ok = 1'b1;
               end
            end
         end
         rvrb_pkg::KIND_QUERY: begin
            if (is_registered(r.ident)) begin
               p.ok    = 1'b1;
               p.lower = shadow_lower[rvrb_pkg::ADDR_W'(r.ident)];
               p.upper = shadow_upper[rvrb_pkg::ADDR_W'(r.ident)];
            end
            if (slot >= 0) begin
               p.value = shadow_bind_value[rvrb_pkg::SLOT_W'(slot)];
               p.fb    = 1'b1;
            end else begin
               p.value = p.upper;
            end
         end
         rvrb_pkg::KIND_RESOLVE: begin
            vid = r.pext[rvrb_pkg::IDENT_W-1:0];
            if (!r.pext[rvrb_pkg::DATA_W-1]) p.value = r.pext;
            else if (is_registered(vid)) p.value = shadow_upper[rvrb_pkg::ADDR_W'(vid)];
         end
         rvrb_pkg::KIND_CLR_REG:  shadow_next = 1;
         rvrb_pkg::KIND_CLR_BIND: shadow_bind_count = 0;
         default: ;
      endcase
      p.count = rvrb_pkg::NID_W'(shadow_next - 1);
      return p;
   endfunction

   function automatic logic [rvrb_pkg::IN_DATA_W-1:0] pack_request(req_type r);
      logic [rvrb_pkg::IN_DATA_W-1:0] d;
      d = '0;
      d[rvrb_pkg::IN_LOWER_LSB +: rvrb_pkg::DATA_W]  = r.lower;
      d[rvrb_pkg::IN_UPPER_LSB +: rvrb_pkg::DATA_W]  = r.upper;
      d[rvrb_pkg::IN_IDENT_LSB +: rvrb_pkg::IDENT_W] = r.ident;
      d[rvrb_pkg::IN_VALUE_LSB +: rvrb_pkg::DATA_W]  = r.value;
      d[rvrb_pkg::IN_PEXT_LSB +: rvrb_pkg::DATA_W]   = r.pext;
      return d;
   endfunction

   // Request of the given kind with every field random
   function automatic req_type rand_req(logic [rvrb_pkg::KIND_W-1:0] k);
      req_type r;
      r.kind  = k;
      r.lower = $urandom;
      r.upper = $urandom;
      r.ident = rvrb_pkg::IDENT_W'($urandom);
      r.value = $urandom;
      r.pext  = $urandom;
      r.drain = 1'b0;
      return r;
   endfunction

   // Mostly ids near the registry, now and then any id
   function automatic logic [rvrb_pkg::IDENT_W-1:0] pick_ident();
      if ($urandom_range(0, 9) == 0) return rvrb_pkg::IDENT_W'($urandom);
      return rvrb_pkg::IDENT_W'($urandom_range(0, 70));
   endfunction

   // Allocate request with an ordered range, or a bad one now and then
   function automatic req_type alloc_req(int bad_odds);
      req_type r;
      r = rand_req(rvrb_pkg::KIND_ALLOC);
      if ($urandom_range(0, 99) >= bad_odds) begin
         if ($urandom_range(0, 1)) r.lower = $urandom_range(0, 1000);
         r.upper = r.lower + $urandom_range(0, ~r.lower);
      end
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input word_type got,
                                input word_type want);
      if (mismatches < PRINT_LIMIT)
         $display("response %0d: %s got %h want %h", responses_seen, what, got, want);
      mismatches++;
   endtask

   // Directed requests, then random scenarios
   initial begin : fill_requests
      req_type r;
      int      total;
      int      fills;
      int      n;
      int      w;
      int      s;
      logic [rvrb_pkg::KIND_W-1:0] k;

      r = rand_req(rvrb_pkg::KIND_QUERY); r.ident = 31'd1; queued_requests.push_back(r);
      r = rand_req(rvrb_pkg::KIND_RESOLVE); r.pext = 32'h8000_0001;
      queued_requests.push_back(r);
      // Bad ranges: zero upper, upper below lower; then full-width and single-value ranges
      r = rand_req(rvrb_pkg::KIND_ALLOC); r.lower = '0; r.upper = '0;
      queued_requests.push_back(r);
      r = rand_req(rvrb_pkg::KIND_ALLOC); r.lower = 32'd5; r.upper = 32'd4;
      queued_requests.push_back(r);
      r = rand_req(rvrb_pkg::KIND_ALLOC); r.lower = '0; r.upper = '1;
      queued_requests.push_back(r);
      r = rand_req(rvrb_pkg::KIND_ALLOC); r.lower = '1; r.upper = '1;
      queued_requests.push_back(r);
      r = rand_req(rvrb_pkg::KIND_ALLOC); r.lower = 32'd1; r.upper = 32'd1;
      queued_requests.push_back(r);
      // Bind to id zero, bind, rebind, bind to an unregistered id
      r = rand_req(rvrb_pkg::KIND_BIND); r.ident = '0; queued_requests.push_back(r);
      r = rand_req(rvrb_pkg::KIND_BIND); r.ident = 31'd1; r.value = '1;
      queued_requests.push_back(r);
      r = rand_req(rvrb_pkg::KIND_BIND); r.ident = 31'd1; r.value = '0;
      queued_requests.push_back(r);
      r = rand_req(rvrb_pkg::KIND_BIND); r.ident = '1; queued_requests.push_back(r);
      r = rand_req(rvrb_pkg::KIND_QUERY); r.ident = 31'd1; queued_requests.push_back(r);
      r = rand_req(rvrb_pkg::KIND_QUERY); r.ident = 31'd2; queued_requests.push_back(r);
      r = rand_req(rvrb_pkg::KIND_QUERY); r.ident = '1; queued_requests.push_back(r);
      r = rand_req(rvrb_pkg::KIND_QUERY); r.ident = '0; queued_requests.push_back(r);
      // Literal and variable extents
      r = rand_req(rvrb_pkg::KIND_RESOLVE); r.pext = '0; queued_requests.push_back(r);
      r = rand_req(rvrb_pkg::KIND_RESOLVE); r.pext = 32'h7FFF_FFFF;
      queued_requests.push_back(r);
      r = rand_req(rvrb_pkg::KIND_RESOLVE); r.pext = 32'h8000_0002;
      queued_requests.push_back(r);
      r = rand_req(rvrb_pkg::KIND_RESOLVE); r.pext = '1; queued_requests.push_back(r);
      r = rand_req(rvrb_pkg::KIND_RESOLVE); r.pext = 32'h8000_0000;
      queued_requests.push_back(r);
      queued_requests.push_back(rand_req(KIND_SPARE_6));
      queued_requests.push_back(rand_req(KIND_SPARE_7));
      queued_requests.push_back(rand_req(rvrb_pkg::KIND_CLR_BIND));
      r = rand_req(rvrb_pkg::KIND_QUERY); r.ident = 31'd1; queued_requests.push_back(r);
      queued_requests.push_back(rand_req(rvrb_pkg::KIND_CLR_REG));
      r = rand_req(rvrb_pkg::KIND_QUERY); r.ident = 31'd1; queued_requests.push_back(r);

      total = 0;
      fills = 0;
      while (total < RANDOM_ITEMS) begin
         s = $urandom_range(0, 9);
         n = queued_requests.size();
         if (s == 0 && fills < MAX_FILLS) begin
            // Try to fill the registry, at times past its last id, then look inside
            fills++;
            queued_requests.push_back(rand_req(rvrb_pkg::KIND_CLR_REG));
            repeat ($urandom_range(rvrb_pkg::REGISTRY_DEPTH - 4, rvrb_pkg::REGISTRY_DEPTH + 4))
               queued_requests.push_back(alloc_req(10));
            repeat (4) begin
               r = rand_req(rvrb_pkg::KIND_QUERY); r.ident = pick_ident();
               queued_requests.push_back(r);
               r = rand_req(rvrb_pkg::KIND_RESOLVE); r.pext = {1'b1, pick_ident()};
               queued_requests.push_back(r);
            end
         end else if (s == 1) begin
            // Fill the binding table with some rebinds among the new ids
            queued_requests.push_back(rand_req(rvrb_pkg::KIND_CLR_BIND));
            repeat ($urandom_range(rvrb_pkg::BIND_DEPTH + 1, rvrb_pkg::BIND_DEPTH + 4)) begin
               r = rand_req(rvrb_pkg::KIND_BIND);
               r.ident = ($urandom_range(0, 15) == 0) ? '0
                                                      : rvrb_pkg::IDENT_W'($urandom_range(1, 12));
               queued_requests.push_back(r);
            end
            repeat (3) begin
               r = rand_req(rvrb_pkg::KIND_QUERY);
               r.ident = rvrb_pkg::IDENT_W'($urandom_range(0, 14));
               queued_requests.push_back(r);
            end
         end else begin
            // Weighted mix of every kind
            repeat ($urandom_range(8, 20)) begin
               w = $urandom_range(0, 99);
               if (w < 25)      k = rvrb_pkg::KIND_ALLOC;
               else if (w < 45) k = rvrb_pkg::KIND_BIND;
               else if (w < 70) k = rvrb_pkg::KIND_QUERY;
               else if (w < 90) k = rvrb_pkg::KIND_RESOLVE;
               else if (w < 93) k = rvrb_pkg::KIND_CLR_REG;
               else if (w < 96) k = rvrb_pkg::KIND_CLR_BIND;
               else if (w < 98) k = KIND_SPARE_6;
               else             k = KIND_SPARE_7;
               r = (k == rvrb_pkg::KIND_ALLOC) ? alloc_req(20) : rand_req(k);
               if (k == rvrb_pkg::KIND_BIND)
                  r.ident = ($urandom_range(0, 9) == 0) ? pick_ident()
                                                        : rvrb_pkg::IDENT_W'($urandom_range(0, 12));
               if (k == rvrb_pkg::KIND_QUERY) r.ident = pick_ident();
               if (k == rvrb_pkg::KIND_RESOLVE && $urandom_range(0, 1))
                  r.pext = {1'b1, pick_ident()};
               queued_requests.push_back(r);
            end
         end
         // Hold off at the head of some scenarios, and always at the first one
         if (total == 0 || $urandom_range(0, 3) == 0) queued_requests[n].drain = 1'b1;
         total += queued_requests.size() - n;
      end
   end

   // Hold reset at the start, then release it once
   initial begin : release_reset
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // Request driver
   int      req_idle = 0;
   bit      req_calm = 1'b0;
   req_type on_bus;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_idle = 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_responses.push_back(predict_response(on_bus));
         if (!req_tvalid || req_tready) begin
            if (req_idle != 0) begin
               req_idle--;
               req_tvalid <= 1'b0;
            end else if (queued_requests.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (queued_requests[0].drain && expected_responses.size() != 0) begin
               req_tvalid <= 1'b0;
            end else begin
               on_bus = queued_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= pack_request(on_bus);
               req_tuser  <= on_bus.kind;
               // Draw the wait before the next request; switch between calm and busy runs
               if ($urandom_range(0, 31) == 0) req_calm = !req_calm;
               req_idle = req_calm ? 0 : $urandom_range(0, STALL_MAX);
            end
         end
      end
   end

   // Response monitor
   int      rsp_stall = 0;
   bit      rsp_calm  = 1'b0;
   rsp_type got;
   rsp_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            responses_seen++;
            got.ok    = rsp_tdata[rvrb_pkg::OUT_OK_LSB];
            got.nid   = rsp_tdata[rvrb_pkg::OUT_NID_LSB +: rvrb_pkg::NID_W];
            got.lower = rsp_tdata[rvrb_pkg::OUT_LOWER_LSB +: rvrb_pkg::DATA_W];
            got.upper = rsp_tdata[rvrb_pkg::OUT_UPPER_LSB +: rvrb_pkg::DATA_W];
            got.value = rsp_tdata[rvrb_pkg::OUT_VALUE_LSB +: rvrb_pkg::DATA_W];
            got.count = rsp_tdata[rvrb_pkg::OUT_COUNT_LSB +: rvrb_pkg::NID_W];
            got.fb    = rsp_tuser;
            if (expected_responses.size() == 0) begin
               flag_mismatch("unexpected transfer, ok", word_type'(got.ok), '0);
            end else begin
               want = expected_responses.pop_front();
               if (got.ok !== want.ok)
                  flag_mismatch("ok", word_type'(got.ok), word_type'(want.ok));
               if (got.nid !== want.nid)
                  flag_mismatch("new_ident", word_type'(got.nid), word_type'(want.nid));
               if (got.lower !== want.lower) flag_mismatch("lower_out", got.lower, want.lower);
               if (got.upper !== want.upper) flag_mismatch("upper_out", got.upper, want.upper);
               if (got.value !== want.value) flag_mismatch("value_out", got.value, want.value);
               if (got.fb !== want.fb)
                  flag_mismatch("from_binding", word_type'(got.fb), word_type'(want.fb));
               if (got.count !== want.count)
                  flag_mismatch("registered_count", word_type'(got.count),
                                word_type'(want.count));
            end
            if ($urandom_range(0, 31) == 0) rsp_calm = !rsp_calm;
            rsp_stall = rsp_calm ? 0 : $urandom_range(0, STALL_MAX);
         end
         if (rsp_stall != 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Wait for the last response, let the block settle, then give the verdict
   initial begin : finish_run
      @(negedge reset);
      while (queued_requests.size() != 0 || req_tvalid || expected_responses.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_responses.size() != 0)
         flag_mismatch("responses outstanding", word_type'(expected_responses.size()), '0);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
